/* sv/bdeq_pkg.sv */
// ----------------------------------------------------------------------------
// bdeq_pkg
// shared types and constants of the bounded double-ended queue
// ----------------------------------------------------------------------------
package bdeq_pkg;

   localparam int KIND_BITS  = 3;
   localparam int CAP_BITS   = 11;
   localparam int COUNT_BITS = 11;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_QUERY      = 3'd4
   } kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RESP = 1'b1
   } state_type;

endpackage

/* sv/bdeq_slot_ram.sv */
// ----------------------------------------------------------------------------
// bdeq_slot_ram
// slot storage, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module bdeq_slot_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/bdeq_rsp_queue.sv */
// ----------------------------------------------------------------------------
// bdeq_rsp_queue
// two-entry result queue between the core and the result channel
// ----------------------------------------------------------------------------
module bdeq_rsp_queue #(
   parameter int DATA_BITS = 80
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 has_room,
   output logic                 out_valid,
   output logic [DATA_BITS-1:0] out_data,
   input  logic                 out_ready
);

   logic [DATA_BITS-1:0] slot0_ff, slot0_in;
   logic [DATA_BITS-1:0] slot1_ff, slot1_in;
   logic [1:0]           count_ff, count_in;
   logic                 pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot0_ff;
   assign has_room  = (count_ff != 2'd2);
   assign pop       = out_valid & out_ready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      priority if (pop && push_valid) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end else if (push_valid) begin
         if (count_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

/* sv/bounded_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// ring-buffer deque of signed words with a programmable capacity
// ----------------------------------------------------------------------------
// an accepted request moves the block to its response state, which pushes the result into the result queue
// one request at a time: req_tready is low in the response state and while the result queue is full
// front and back words are cached in registers; pops refill them from the ram
// reset: synchronous, clears pointers, count and queue; capacity returns to 1024
// slot ram has no reset and no clearing pass
module bounded_double_ended_queue #(
   parameter int MAX_DEPTH = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [bdeq_pkg::CAP_BITS-1:0]         csr_wr_data,   // capacity
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((WORD_BITS+7)/8)*8-1:0]        req_tdata,     // value
   input  logic [bdeq_pkg::KIND_BITS-1:0]        req_tuser,     // kind
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // accepted, front_value, back_value, entry_count, empty_flag, full_flag
   output logic [((2*WORD_BITS+14+7)/8)*8-1:0]   rsp_tdata
);

   localparam int IDX_BITS  = $clog2(MAX_DEPTH);
   localparam int LIM_BITS  = ($clog2(MAX_DEPTH+1) > bdeq_pkg::COUNT_BITS) ?
                              $clog2(MAX_DEPTH+1) : bdeq_pkg::COUNT_BITS;
   localparam int RSP_BITS  = ((2*WORD_BITS+14+7)/8)*8;

   function automatic logic [IDX_BITS-1:0] ring_next(input logic [IDX_BITS-1:0] i);
      return (i == IDX_BITS'(MAX_DEPTH-1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_BITS-1:0] ring_prev(input logic [IDX_BITS-1:0] i);
      return (i == '0) ? IDX_BITS'(MAX_DEPTH-1) : i - 1'b1;
   endfunction

   bdeq_pkg::state_type state_ff, state_in;

   logic [IDX_BITS-1:0]             head_ff, head_in;
   logic [IDX_BITS-1:0]             tail_ff, tail_in;
   logic [LIM_BITS-1:0]             occ_ff, occ_in;
   logic [bdeq_pkg::CAP_BITS-1:0]   cap_ff;
   logic [WORD_BITS-1:0]            front_ff, front_in;
   logic [WORD_BITS-1:0]            back_ff, back_in;
   logic                            ok_ff, ok_in;
   logic                            rd_front_ff, rd_front_in;
   logic                            rd_back_ff, rd_back_in;

   logic [LIM_BITS-1:0]  cap_wide, limit_wide;
   logic                 room, some, accept_req;
   logic [WORD_BITS-1:0] word;
   bdeq_pkg::kind_type   kind;

   logic                 wr_en, rd_en;
   logic [IDX_BITS-1:0]  wr_addr, rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   logic                 q_room, q_push;
   logic [WORD_BITS-1:0] front_val, back_val, front_out, back_out;
   logic                 empty_now, full_now;
   logic [RSP_BITS-1:0]  rsp_word;

   assign cap_wide   = LIM_BITS'(cap_ff);
   assign limit_wide = (cap_wide > LIM_BITS'(MAX_DEPTH)) ? LIM_BITS'(MAX_DEPTH) : cap_wide;
   assign room       = occ_ff < limit_wide;
   assign some       = (occ_ff != '0);
   assign word       = req_tdata[WORD_BITS-1:0];
   assign kind       = bdeq_pkg::kind_type'(req_tuser);
   assign req_tready = (state_ff == bdeq_pkg::ST_IDLE) && q_room;
   assign accept_req = req_tvalid && req_tready;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      front_in    = front_ff;
      back_in     = back_ff;
      ok_in       = ok_ff;
      rd_front_in = rd_front_ff;
      rd_back_in  = rd_back_ff;
      wr_en       = 1'b0;
      wr_addr     = tail_ff;
      rd_en       = 1'b0;
      rd_addr     = head_ff;
      q_push      = 1'b0;
      unique case (state_ff)
         bdeq_pkg::ST_IDLE: begin
            if (accept_req) begin
               state_in    = bdeq_pkg::ST_RESP;
               ok_in       = 1'b0;
               rd_front_in = 1'b0;
               rd_back_in  = 1'b0;
               unique case (kind)
                  bdeq_pkg::KIND_PUSH_FRONT: begin
                     if (room) begin
                        head_in  = ring_prev(head_ff);
                        wr_en    = 1'b1;
                        wr_addr  = ring_prev(head_ff);
                        front_in = word;
                        if (!some) begin
                           back_in = word;
                        end
                        occ_in = occ_ff + 1'b1;
                        ok_in  = 1'b1;
                     end
                  end
                  bdeq_pkg::KIND_PUSH_BACK: begin
                     if (room) begin
                        tail_in = ring_next(tail_ff);
                        wr_en   = 1'b1;
                        wr_addr = tail_ff;
                        back_in = word;
                        if (!some) begin
                           front_in = word;
                        end
                        occ_in = occ_ff + 1'b1;
                        ok_in  = 1'b1;
                     end
                  end
                  bdeq_pkg::KIND_POP_FRONT: begin
                     if (some) begin
                        head_in     = ring_next(head_ff);
                        rd_en       = 1'b1;
                        rd_addr     = ring_next(head_ff);
                        rd_front_in = 1'b1;
                        occ_in      = occ_ff - 1'b1;
                        ok_in       = 1'b1;
                     end
                  end
                  bdeq_pkg::KIND_POP_BACK: begin
                     if (some) begin
                        tail_in    = ring_prev(tail_ff);
                        rd_en      = 1'b1;
                        rd_addr    = ring_prev(ring_prev(tail_ff));
                        rd_back_in = 1'b1;
                        occ_in     = occ_ff - 1'b1;
                        ok_in      = 1'b1;
                     end
                  end
                  bdeq_pkg::KIND_QUERY: begin
                     ok_in = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         bdeq_pkg::ST_RESP: begin
            q_push   = 1'b1;
            front_in = front_val;
            back_in  = back_val;
            state_in = bdeq_pkg::ST_IDLE;
         end
         default: begin
            state_in = bdeq_pkg::ST_IDLE;
         end
      endcase
   end

   // result assembly from the state left by the item
   assign front_val = rd_front_ff ? rd_data : front_ff;
   assign back_val  = rd_back_ff ? rd_data : back_ff;
   assign empty_now = (occ_ff == '0);
   assign full_now  = occ_ff >= limit_wide;
   assign front_out = empty_now ? '1 : front_val;
   assign back_out  = empty_now ? '1 : back_val;
   assign rsp_word  = RSP_BITS'({full_now, empty_now, occ_ff[bdeq_pkg::COUNT_BITS-1:0],
                                 back_out, front_out, ok_ff});

   always_ff @(posedge clock) begin
      front_ff <= front_in;
      back_ff  <= back_in;
      ok_ff    <= ok_in;
      if (reset) begin
         state_ff    <= bdeq_pkg::ST_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         occ_ff      <= '0;
         cap_ff      <= bdeq_pkg::CAP_RESET;
         rd_front_ff <= 1'b0;
         rd_back_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         occ_ff      <= occ_in;
         rd_front_ff <= rd_front_in;
         rd_back_ff  <= rd_back_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   bdeq_slot_ram #(
      .DEPTH (MAX_DEPTH),
      .WIDTH (WORD_BITS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bdeq_rsp_queue #(
      .DATA_BITS (RSP_BITS)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_data  (rsp_word),
      .has_room   (q_room),
      .out_valid  (rsp_tvalid),
      .out_data   (rsp_tdata),
      .out_ready  (rsp_tready)
   );

endmodule

/* tb/bounded_double_ended_queue_checker.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_checker
// watches the request, result and csr channels of the deque, keeps its own
// ring-buffer copy of the deque and compares every result transfer, field by
// field, with the oldest predicted status
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [bdeq_pkg::CAP_BITS-1:0]   csr_wr_data,   // capacity
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [31:0]                     req_tdata,     // value
   input  logic [bdeq_pkg::KIND_BITS-1:0]  req_tuser,     // kind
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // accepted, front_value, back_value, entry_count, empty_flag, full_flag
   input  logic [79:0]                     rsp_tdata,
   output int                              error_count,
   output int                              pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS    = 1024;
   localparam int RSP_BITS = 80;

   localparam logic [bdeq_pkg::CAP_BITS-1:0] SLOT_LIMIT = 11'd1024;

   typedef struct packed {
      logic                            full_flag;
      logic                            empty_flag;
      logic [bdeq_pkg::COUNT_BITS-1:0] entry_count;
      logic [31:0]                     back_value;
      logic [31:0]                     front_value;
      logic                            accepted;
   } deque_status_type;

   localparam int STATUS_BITS = $bits(deque_status_type);

   logic [31:0]                     slot_ram [SLOTS];
   logic [9:0]                      head_ptr;
   logic [9:0]                      tail_ptr;
   logic [bdeq_pkg::COUNT_BITS-1:0] held_count;
   logic [bdeq_pkg::CAP_BITS-1:0]   cap_reg;
   deque_status_type                expected_status_q [$];
   deque_status_type                want;
   deque_status_type                got;
   int                              mismatch_total = 0;

   function automatic deque_status_type predict_op(
         input logic [bdeq_pkg::KIND_BITS-1:0] kind,
         input logic [31:0] word);
      deque_status_type              s;
      logic [bdeq_pkg::CAP_BITS-1:0] limit;
      logic                          room;
      logic                          some;
      limit = (cap_reg > SLOT_LIMIT) ? SLOT_LIMIT : cap_reg;
      room  = held_count < limit;
      some  = held_count != 0;
      s.accepted = 1'b0;
      unique case (kind)
         bdeq_pkg::KIND_PUSH_FRONT: if (room) begin
            head_ptr = head_ptr - 1'b1;
            slot_ram[head_ptr] = word;
            held_count = held_count + 1'b1;
            s.accepted = 1'b1;
         end
         bdeq_pkg::KIND_PUSH_BACK: if (room) begin
            slot_ram[tail_ptr] = word;
            tail_ptr = tail_ptr + 1'b1;
            held_count = held_count + 1'b1;
            s.accepted = 1'b1;
         end
         bdeq_pkg::KIND_POP_FRONT: if (some) begin
            head_ptr = head_ptr + 1'b1;
            held_count = held_count - 1'b1;
            s.accepted = 1'b1;
         end
         bdeq_pkg::KIND_POP_BACK: if (some) begin
            tail_ptr = tail_ptr - 1'b1;
            held_count = held_count - 1'b1;
            s.accepted = 1'b1;
         end
         bdeq_pkg::KIND_QUERY: s.accepted = 1'b1;
         default: s.accepted = 1'b0;
      endcase
      if (held_count != 0) begin
         s.front_value = slot_ram[head_ptr];
         s.back_value  = slot_ram[tail_ptr - 1'b1];
      end else begin
         s.front_value = '1;
         s.back_value  = '1;
      end
      s.entry_count = held_count;
      s.empty_flag  = held_count == 0;
      s.full_flag   = held_count >= limit;
      return s;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                         input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         mismatch_total++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         head_ptr   = '0;
         tail_ptr   = '0;
         held_count = '0;
         cap_reg    = bdeq_pkg::CAP_RESET;
         expected_status_q.delete();
      end else begin
         if (csr_wr_en) cap_reg = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[STATUS_BITS-1:0];
            if (expected_status_q.size() == 0) begin
               $display("%0t ns: unexpected result transfer, expected none, actual %h",
                        $time, rsp_tdata);
               mismatch_total++;
            end else begin
               want = expected_status_q.pop_front();
               compare_field("accepted", want.accepted, got.accepted);
               compare_field("front_value", want.front_value, got.front_value);
               compare_field("back_value", want.back_value, got.back_value);
               compare_field("entry_count", want.entry_count, got.entry_count);
               compare_field("empty_flag", want.empty_flag, got.empty_flag);
               compare_field("full_flag", want.full_flag, got.full_flag);
               compare_field("padding", '0, rsp_tdata[RSP_BITS-1:STATUS_BITS]);
            end
         end
         if (req_tvalid && req_tready)
            expected_status_q.push_back(predict_op(req_tuser, req_tdata));
      end
      pending_results <= expected_status_q.size();
      error_count     <= mismatch_total;
   end

endmodule

/* tb/bounded_double_ended_queue_tb.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_tb
// drives push, pop, query and invalid-kind requests into the deque under several capacity
// settings, with random gaps and stalls on both channels; a checker beside
// the block predicts and compares every result
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_BITS   = 32;
   localparam int REQ_BITS    = ((WORD_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = ((2 * WORD_BITS + 14 + 7) / 8) * 8;
   localparam int HOLD_CYCLES = 300;

   localparam logic [bdeq_pkg::KIND_BITS-1:0] KIND_BAD_LO  = 3'd5;
   localparam logic [bdeq_pkg::KIND_BITS-1:0] KIND_BAD_MID = 3'd6;
   localparam logic [bdeq_pkg::KIND_BITS-1:0] KIND_BAD_HI  = 3'd7;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           csr_wr_en   = 1'b0;
   logic [bdeq_pkg::CAP_BITS-1:0]  csr_wr_data = '0;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [REQ_BITS-1:0]            req_tdata   = '0;   // value
   logic [bdeq_pkg::KIND_BITS-1:0] req_tuser   = bdeq_pkg::KIND_QUERY;   // kind
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   // accepted, front_value, back_value, entry_count, empty_flag, full_flag
   logic [RSP_BITS-1:0]            rsp_tdata;
   int                             error_count;
   int                             pending_results;
   logic                           hold_off_req = 1'b0;
   int                             sent_total   = 0;

   bounded_double_ended_queue dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   bounded_double_ended_queue_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // result side: random stalls, one long hold-off, one stall-free stretch
   initial begin
      int cycle_no;
      cycle_no = 0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            cycle_no += HOLD_CYCLES;
         end else if (cycle_no >= 2000 && cycle_no < 3500) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 8);
         end
      end
   end

   function automatic logic [31:0] pick_word();
      unique case ($urandom_range(15))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [bdeq_pkg::KIND_BITS-1:0] pick_kind(input int push_pct,
                                                                input int pop_pct);
      int          r;
      logic [31:0] bad;
      r   = $urandom_range(99);
      bad = $urandom_range(KIND_BAD_HI, KIND_BAD_LO);
      if (r < push_pct)
         return $urandom_range(1) ? bdeq_pkg::KIND_PUSH_BACK : bdeq_pkg::KIND_PUSH_FRONT;
      if (r < push_pct + pop_pct)
         return $urandom_range(1) ? bdeq_pkg::KIND_POP_BACK : bdeq_pkg::KIND_POP_FRONT;
      if (r < 96) return bdeq_pkg::KIND_QUERY;
      return bad[bdeq_pkg::KIND_BITS-1:0];
   endfunction

   task automatic send_op(input logic [bdeq_pkg::KIND_BITS-1:0] kind, input logic [31:0] word);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      sent_total++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [bdeq_pkg::CAP_BITS-1:0] cap);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int n, input int push_pct, input int pop_pct);
      for (int i = 0; i < n; i++) begin
         // no request gaps for a stretch of transfers
         if (!(sent_total >= 600 && sent_total < 900) && $urandom_range(99) < 8) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         send_op(pick_kind(push_pct, pop_pct), pick_word());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_op(bdeq_pkg::KIND_QUERY, '0);
      send_op(bdeq_pkg::KIND_POP_FRONT, '1);
      send_op(bdeq_pkg::KIND_POP_BACK, '0);
      send_op(KIND_BAD_LO, 32'h1234_5678);
      send_op(KIND_BAD_HI, '1);
      send_op(bdeq_pkg::KIND_PUSH_BACK, 32'h7fff_ffff);
      send_op(bdeq_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
      send_op(bdeq_pkg::KIND_PUSH_BACK, '0);
      send_op(bdeq_pkg::KIND_PUSH_FRONT, '1);
      send_op(bdeq_pkg::KIND_PUSH_BACK, 32'h5555_5555);
      send_op(bdeq_pkg::KIND_PUSH_FRONT, 32'haaaa_aaaa);
      send_op(bdeq_pkg::KIND_QUERY, 32'hdead_beef);
      send_op(KIND_BAD_MID, '0);
      send_op(bdeq_pkg::KIND_POP_FRONT, '0);
      send_op(bdeq_pkg::KIND_POP_BACK, '0);
      send_op(bdeq_pkg::KIND_POP_BACK, '0);
      send_op(bdeq_pkg::KIND_POP_FRONT, '0);
      send_op(bdeq_pkg::KIND_POP_FRONT, '0);
      send_op(bdeq_pkg::KIND_POP_BACK, '0);
      send_op(bdeq_pkg::KIND_POP_BACK, '0);

      write_capacity(11'd0);
      send_op(bdeq_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
      send_op(bdeq_pkg::KIND_PUSH_BACK, 32'h7fff_ffff);
      send_op(bdeq_pkg::KIND_QUERY, '0);
      run_random(10, 45, 30);

      write_capacity(11'd1);
      run_random(30, 45, 35);
      write_capacity(11'd2);
      run_random(30, 45, 35);

      // results held back while requests keep coming
      write_capacity(11'd7);
      hold_off_req <= 1'b1;
      @(posedge clock);
      hold_off_req <= 1'b0;
      run_random(50, 45, 35);

      // fill, then shrink the capacity below the count
      write_capacity(11'd16);
      run_random(20, 85, 5);
      write_capacity(11'd3);
      run_random(30, 25, 55);

      // capacity above the ring size, filled until full
      write_capacity(11'd2047);
      run_random(1040, 100, 0);
      write_capacity(11'd5);
      run_random(30, 40, 50);
      write_capacity(11'd1024);
      run_random(20, 45, 45);

      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_results == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/bdeq_pkg.sv
sv/bdeq_slot_ram.sv
sv/bdeq_rsp_queue.sv
sv/bounded_double_ended_queue.sv
tb/bounded_double_ended_queue_checker.sv
tb/bounded_double_ended_queue_tb.sv
